@@ hw/rtl/pdpd_pkg.sv @@
// shared types and constants for the parity deframer and prefix decoder
package pdpd_pkg;
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_LOAD  = 2'd1;
   localparam logic [1:0] CMD_START = 2'd2;
   localparam logic [1:0] CMD_HEX   = 2'd3;
   localparam int FRAME_BITS = 9;
   localparam int KEEP_BITS  = 8;
   localparam int CODE_W     = 16;
   localparam int LEN_W      = 5;
   localparam int SYM_W      = 8;
   localparam int CNT_W      = 16;
   localparam logic [CNT_W-1:0] MAX_CHARS_RESET = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_SCAN,
      ST_BIT,
      ST_SCAN,
      ST_EMIT,
      ST_NIB_DONE
   } state_type;

   typedef struct packed {
      logic clear_book;
      logic start_msg;
      logic load_begin;
      logic load_step;
      logic load_commit;
      logic hex_capture;
      logic bit_begin;
      logic scan_step;
      logic nib_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_end;
      logic load_hit;
      logic frame_ready;
      logic bit_skip;
      logic match;
      logic emit_ok;
      logic bits_left;
      logic nib_left;
      logic any_out;
   } ctrl_sts_type;
endpackage

@@ hw/rtl/pdpd_if.sv @@
// valid/ready channel carrying a payload
interface pdpd_if #(parameter int W = 8) (input logic clock);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/pdpd_datapath.sv @@
// frame shifter, codebook memory, accumulator and output register
module pdpd_datapath
   import pdpd_pkg::*;
#(
   parameter int NUM_CODES    = 64,
   parameter int MAX_CODE_LEN = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output ctrl_sts_type        sts,
   input  logic [3:0]          in_nibble,
   input  logic [CODE_W-1:0]   in_code_bits,
   input  logic [LEN_W-1:0]    in_code_length,
   input  logic [SYM_W-1:0]    in_code_symbol,
   input  logic [CNT_W-1:0]    max_chars,
   input  logic                out_push,
   input  logic                out_load,
   output logic [SYM_W-1:0]    out_symbol
);
   localparam int IW = $clog2(NUM_CODES);
   localparam int CW = $clog2(NUM_CODES + 1);
   localparam int AW = $clog2(MAX_CODE_LEN + 2);

   logic [CODE_W-1:0] mem_code [NUM_CODES];
   logic [LEN_W-1:0]  mem_len  [NUM_CODES];
   logic [SYM_W-1:0]  mem_sym  [NUM_CODES];
   logic [CODE_W-1:0] rd_code_ff;
   logic [LEN_W-1:0]  rd_len_ff;
   logic [SYM_W-1:0]  rd_sym_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] hit_ff, hit_in;
   logic          hit_v_ff, hit_v_in;
   logic [CODE_W-1:0] ld_code_ff;
   logic [LEN_W-1:0]  ld_len_ff;
   logic [SYM_W-1:0]  ld_sym_ff;
   logic [8:0] frame_ff, frame_in;
   logic [3:0] fill_ff, fill_in;
   logic [3:0] nib_ff, nib_in;
   logic [1:0] nk_ff, nk_in;
   logic [8:0] kept_ff, kept_in;
   logic [2:0] bk_ff, bk_in;
   logic [MAX_CODE_LEN-1:0] acc_ff, acc_in;
   logic [AW-1:0] alen_ff, alen_in;
   logic ovf_ff, ovf_in;
   logic [CNT_W-1:0] emit_ff, emit_in;
   logic [SYM_W-1:0] osym_ff, osym_in;
   logic [SYM_W-1:0] hold_ff, hold_in;
   logic match_ff, match_in;
   logic [SYM_W-1:0] msym_ff, msym_in;

   logic [IW-1:0] rd_addr;
   logic [31:0] mask32, lmask32;
   logic [CODE_W-1:0] ld_masked;
   logic [8:0] next_frame;
   logic [CODE_W-1:0] acc_cmp;
   logic entry_match, scan_active;

   assign rd_addr = idx_in[IW-1:0];
   always_ff @(posedge clock) begin
      rd_code_ff <= mem_code[rd_addr];
      rd_len_ff  <= mem_len[rd_addr];
      rd_sym_ff  <= mem_sym[rd_addr];
      if (cmd.load_commit && (hit_v_ff || count_ff < CW'(NUM_CODES))) begin
         if (hit_v_ff) begin
            mem_sym[hit_ff[IW-1:0]] <= ld_sym_ff;
         end else begin
            mem_code[count_ff[IW-1:0]] <= ld_masked;
            mem_len[count_ff[IW-1:0]]  <= ld_len_ff;
            mem_sym[count_ff[IW-1:0]]  <= ld_sym_ff;
         end
      end
   end

   assign lmask32 = (ld_len_ff >= LEN_W'(16)) ? 32'hFFFF_FFFF
                                              : ((32'd1 << ld_len_ff) - 32'd1);
   assign ld_masked = ld_code_ff & lmask32[CODE_W-1:0];
   assign mask32 = (rd_len_ff >= LEN_W'(16)) ? 32'hFFFF_FFFF
                                             : ((32'd1 << rd_len_ff) - 32'd1);
   always_comb begin
      acc_cmp = '0;
      for (int i = 0; i < CODE_W && i < MAX_CODE_LEN; i++) begin
         acc_cmp[i] = acc_ff[i];
      end
   end
   assign scan_active = idx_ff < count_ff;
   assign entry_match = scan_active && !ovf_ff && (32'(rd_len_ff) == 32'(alen_ff)) &&
                        rd_len_ff != '0 && 32'(rd_len_ff) <= 32'(MAX_CODE_LEN) &&
                        ((acc_cmp & mask32[CODE_W-1:0]) == rd_code_ff);
   assign next_frame = {frame_ff[7:0], nib_ff[nk_ff]};

   always_comb begin
      count_in = count_ff; idx_in = idx_ff; hit_in = hit_ff; hit_v_in = hit_v_ff;
      frame_in = frame_ff; fill_in = fill_ff; nib_in = nib_ff; nk_in = nk_ff;
      kept_in = kept_ff; bk_in = bk_ff; acc_in = acc_ff; alen_in = alen_ff;
      ovf_in = ovf_ff; emit_in = emit_ff; osym_in = osym_ff; hold_in = hold_ff;
      match_in = match_ff; msym_in = msym_ff;
      if (cmd.clear_book) count_in = '0;
      if (cmd.start_msg) begin
         frame_in = '0; fill_in = '0; acc_in = '0; alen_in = '0;
         ovf_in = 1'b0; emit_in = '0;
      end
      if (cmd.load_begin) begin
         idx_in = '0; hit_v_in = 1'b0;
      end
      if (cmd.load_step) begin
         if (scan_active && !hit_v_ff && rd_len_ff == ld_len_ff &&
             rd_code_ff == ld_masked) begin
            hit_v_in = 1'b1; hit_in = idx_ff;
         end
         idx_in = idx_ff + CW'(1);
      end
      if (cmd.load_commit && !hit_v_ff && count_ff < CW'(NUM_CODES))
         count_in = count_ff + CW'(1);
      if (cmd.hex_capture) begin
         nib_in = in_nibble; nk_in = 2'd3;
      end
      if (cmd.nib_step) begin
         nk_in = nk_ff - 2'd1;
         if (fill_ff == 4'd8) begin
            fill_in = '0; frame_in = '0; kept_in = next_frame; bk_in = 3'd0;
         end else begin
            fill_in = fill_ff + 4'd1; frame_in = next_frame;
         end
      end
      if (cmd.bit_begin) begin
         idx_in = '0; match_in = 1'b0;
         if (!ovf_ff) begin
            acc_in = {acc_ff[MAX_CODE_LEN-2:0], kept_ff[4'd8 - {1'b0, bk_ff}]};
            if (32'(alen_ff) + 1 > MAX_CODE_LEN) ovf_in = 1'b1;
            else alen_in = alen_ff + AW'(1);
         end
      end
      if (cmd.scan_step) begin
         idx_in = idx_ff + CW'(1);
         if (entry_match && !match_ff) begin
            match_in = 1'b1; msym_in = rd_sym_ff;
         end
      end
      if (out_push) begin
         hold_in = msym_ff;
      end
      if (out_load) begin
         osym_in = hold_ff;
      end
   end

   // match resolution happens in the controller's emit state
   logic resolve;
   assign resolve = cmd.load_commit == 1'b0 && match_ff && !scan_active &&
                    !cmd.scan_step && !cmd.bit_begin && !cmd.nib_step &&
                    (out_push || !(emit_ff < max_chars));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; frame_ff <= '0; fill_ff <= '0; acc_ff <= '0;
         alen_ff <= '0; ovf_ff <= 1'b0; emit_ff <= '0; match_ff <= 1'b0;
         idx_ff <= '0; hit_v_ff <= 1'b0; bk_ff <= '0; nk_ff <= '0;
      end else begin
         count_ff <= count_in; frame_ff <= frame_in; fill_ff <= fill_in;
         idx_ff <= idx_in; hit_v_ff <= hit_v_in; nk_ff <= nk_in;
         ovf_ff <= ovf_in;
         if (resolve) begin
            acc_ff <= '0; alen_ff <= '0; match_ff <= 1'b0;
            if (emit_ff < max_chars) emit_ff <= emit_ff + CNT_W'(1);
            else emit_ff <= emit_in;
         end else begin
            acc_ff <= acc_in; alen_ff <= alen_in; match_ff <= match_in;
            emit_ff <= emit_in;
         end
         if (cmd.bit_begin) bk_ff <= bk_ff + 3'd1;
         else bk_ff <= bk_in;
      end
   end
   always_ff @(posedge clock) begin
      hit_ff <= hit_in; nib_ff <= nib_in; kept_ff <= kept_in;
      osym_ff <= osym_in; hold_ff <= hold_in; msym_ff <= msym_in;
      if (cmd.load_begin) begin
         ld_code_ff <= in_code_bits; ld_len_ff <= in_code_length;
         ld_sym_ff <= in_code_symbol;
      end
   end

   assign out_symbol      = osym_ff;
   assign sts.scan_end    = !scan_active;
   assign sts.load_hit    = hit_v_ff;
   assign sts.frame_ready = fill_ff == 4'd8 && (^next_frame);
   assign sts.bit_skip    = ovf_ff;
   assign sts.match       = match_ff;
   assign sts.emit_ok     = emit_ff < max_chars;
   assign sts.bits_left   = bk_ff != 3'd0;
   assign sts.nib_left    = nk_ff != 2'd0;
   assign sts.any_out     = 1'b0;
endmodule

@@ hw/rtl/pdpd_ctrl.sv @@
// sequencing controller
module pdpd_ctrl
   import pdpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [1:0]   req_cmd,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output logic         rsp_last,
   output logic         out_push,
   output logic         out_load,
   output ctrl_cmd_type cmd,
   input  ctrl_sts_type sts
);
   state_type state_ff, state_in;
   logic      pend_ff, pend_in;
   logic      oval_ff, oval_in;
   logic      olast_ff, olast_in;
   logic      last_nib_ff, last_nib_in;
   logic      accept, out_free, emit_now, flush;

   assign accept   = req_valid && req_ready;
   assign out_free = !oval_ff || rsp_ready;
   assign emit_now = state_ff == ST_EMIT && sts.match && sts.emit_ok;
   assign flush    = state_ff == ST_IDLE && pend_ff && out_free;
   assign out_load = (out_push && pend_ff) || flush;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_LOAD: state_in = ST_LOAD_SCAN;
                  CMD_HEX:  state_in = ST_NIB_DONE;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD_SCAN: if (sts.scan_end) state_in = ST_IDLE;
         ST_NIB_DONE: begin
            if (sts.frame_ready) state_in = ST_BIT;
            else if (!sts.nib_left) state_in = ST_IDLE;
         end
         ST_BIT: state_in = sts.bit_skip ? ST_EMIT : ST_SCAN;
         ST_SCAN: if (sts.scan_end) state_in = ST_EMIT;
         ST_EMIT: begin
            if (!(sts.match && sts.emit_ok) || out_free) begin
               if (sts.bits_left) state_in = ST_BIT;
               else if (last_nib_ff) state_in = ST_IDLE;
               else state_in = ST_NIB_DONE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = state_ff == ST_IDLE && !pend_ff && out_free;
      out_push = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_CLEAR: cmd.clear_book = 1'b1;
                  CMD_LOAD:  cmd.load_begin = 1'b1;
                  CMD_START: cmd.start_msg = 1'b1;
                  CMD_HEX:   cmd.hex_capture = 1'b1;
                  default:   cmd = '0;
               endcase
            end
         end
         ST_LOAD_SCAN: begin
            if (sts.scan_end) cmd.load_commit = 1'b1;
            else cmd.load_step = 1'b1;
         end
         ST_NIB_DONE: cmd.nib_step = 1'b1;
         ST_BIT:  cmd.bit_begin = 1'b1;
         ST_SCAN: cmd.scan_step = !sts.scan_end;
         ST_EMIT: out_push = emit_now && out_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      pend_in = pend_ff; oval_in = oval_ff; olast_in = olast_ff;
      last_nib_in = last_nib_ff;
      if (rsp_valid && rsp_ready) oval_in = 1'b0;
      if (state_ff == ST_NIB_DONE) last_nib_in = !sts.nib_left;
      if (out_push) begin
         if (pend_ff) begin
            oval_in = 1'b1; olast_in = 1'b0;
         end
         pend_in = 1'b1;
      end
      if (flush) begin
         oval_in = 1'b1; olast_in = 1'b1; pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; pend_ff <= 1'b0; oval_ff <= 1'b0;
         olast_ff <= 1'b0; last_nib_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pend_ff <= pend_in; oval_ff <= oval_in;
         olast_ff <= olast_in; last_nib_ff <= last_nib_in;
      end
   end

   assign rsp_valid = oval_ff;
   assign rsp_last  = olast_ff;
endmodule

@@ hw/rtl/parity_deframe_prefix_decoder_unit.sv @@
// top level of the parity deframer and prefix decoder
//  channel | direction | payload
//  req     | in        | cmd, nibble, code_bits, code_length, code_symbol
//  rsp     | out       | symbol, last_of_run
//  csr     | in        | max_chars at byte 0
// a hex digit's time is set by the serial codebook scan, run once per kept bit,
// kept_bits being 0 or 8; after overflow a kept bit skips the scan
// a held result is flushed while idle; a load is one serial scan of the codebook
// one result is held back so last_of_run is known; rsp stalls hold the emit step
// reset is synchronous, clears control state and sets the symbol limit to 65535
module parity_deframe_prefix_decoder_unit
   import pdpd_pkg::*;
#(
   parameter int NUM_CODES    = 64,
   parameter int MAX_CODE_LEN = 16
) (
   input  logic        clock,
   input  logic        reset,
   pdpd_if.sink        req,
   pdpd_if.source      rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;
   logic [CNT_W-1:0] max_chars_ff;
   logic out_push, out_load, rsp_last;
   logic [SYM_W-1:0] sym;

   assign csr_pready = 1'b1;
   assign csr_prdata = 32'(max_chars_ff);
   always_ff @(posedge clock) begin
      if (reset) max_chars_ff <= MAX_CHARS_RESET;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 1'b0)
         max_chars_ff <= csr_pwdata[CNT_W-1:0];
   end

   pdpd_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready), .req_cmd(req.data[1:0]),
      .rsp_ready(rsp.ready), .rsp_valid(rsp.valid), .rsp_last,
      .out_push, .out_load, .cmd, .sts
   );

   pdpd_datapath #(.NUM_CODES(NUM_CODES), .MAX_CODE_LEN(MAX_CODE_LEN)) u_dp (
      .clock, .reset, .cmd, .sts,
      .in_nibble(req.data[5:2]), .in_code_bits(req.data[21:6]),
      .in_code_length(req.data[26:22]), .in_code_symbol(req.data[34:27]),
      .max_chars(max_chars_ff), .out_push, .out_load, .out_symbol(sym)
   );

   assign rsp.data = {rsp_last, sym};
endmodule
